/* hw/rtl/nlac_pkg.sv */
package nlac_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FLOOR_W  = 37;
    localparam int PROD_W   = 33;
    localparam int POWER_W  = 32;
    localparam int QUO_W    = 16;

    localparam logic [QUO_W-1:0] SAT_POS = 16'h7fff;
    localparam logic [QUO_W-1:0] SAT_NEG = 16'h8000;

    typedef enum logic [2:0] {
        F_CLEAR,
        F_IDLE,
        F_RD1,
        F_RD2,
        F_MUL,
        F_UPD,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_DONE
    } t_back_state;

endpackage

/* hw/rtl/nlac_fifo.sv */
module nlac_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

/* hw/rtl/nlac_front.sv */
module nlac_front #(
    parameter int WINDOW_LEN = 64,
    parameter int LAG        = 64,
    parameter int PS_W       = 39,
    parameter int PW_SUM_W   = 38,
    parameter int DIV_W      = 38
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [nlac_pkg::FLOOR_W-1:0]    i_floor,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [nlac_pkg::SAMPLE_W-1:0] i_re,
    input  logic signed [nlac_pkg::SAMPLE_W-1:0] i_im,
    output logic                            o_push,
    input  logic                            i_full,
    output logic signed [PS_W-1:0]          o_sum_re,
    output logic signed [PS_W-1:0]          o_sum_im,
    output logic [DIV_W-1:0]                o_div,
    output logic                            o_floor_hit
);
    import nlac_pkg::*;

    localparam int PWR_D = LAG + WINDOW_LEN;
    localparam int SA_W  = (LAG > 1) ? $clog2(LAG) : 1;
    localparam int PA_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int WA_W  = $clog2(PWR_D);

    t_front_state r_state, n_state;

    logic [2*SAMPLE_W-1:0] r_smp_mem [LAG];
    logic [PROD_W-1:0]     r_pre_mem [WINDOW_LEN];
    logic [PROD_W-1:0]     r_pim_mem [WINDOW_LEN];
    logic [POWER_W-1:0]    r_pwr_mem [PWR_D];

    logic [2*SAMPLE_W-1:0] r_smp_rd;
    logic [PROD_W-1:0]     r_pre_rd;
    logic [PROD_W-1:0]     r_pim_rd;
    logic [POWER_W-1:0]    r_pwr_rd;

    logic [SA_W-1:0] r_spos;
    logic [PA_W-1:0] r_ppos;
    logic [WA_W-1:0] r_wpos;
    logic [WA_W-1:0] r_clr;
    logic [2:0]      r_k;

    logic signed [SAMPLE_W-1:0] r_re, r_im;
    logic signed [PROD_W-1:0]   r_pr, r_pi, r_pw;
    logic [POWER_W-1:0]         r_pwin, r_plag;

    logic signed [PS_W-1:0] r_ps_re, r_ps_im;
    logic [PW_SUM_W-1:0]    r_pw_rec, r_pw_lag;

    logic [WA_W:0]   w_pos_x, w_win_x, w_lag_x;
    logic [WA_W-1:0] w_pwr_ra;
    logic            w_clr_last;

    logic signed [SAMPLE_W-1:0]   w_ma, w_mb, w_ore, w_oim;
    logic signed [2*SAMPLE_W-1:0] w_mul;
    logic signed [PROD_W-1:0]     w_mul_x;

    logic [DIV_W-1:0] w_max, w_floor, w_div;
    logic             w_hit;

    // window and lag taps in the power line
    assign w_pos_x  = {1'b0, r_wpos};
    assign w_win_x  = (w_pos_x >= (WA_W+1)'(WINDOW_LEN)) ? w_pos_x - (WA_W+1)'(WINDOW_LEN)
                                                         : w_pos_x + (WA_W+1)'(LAG);
    assign w_lag_x  = (w_pos_x >= (WA_W+1)'(LAG)) ? w_pos_x - (WA_W+1)'(LAG)
                                                  : w_pos_x + (WA_W+1)'(WINDOW_LEN);
    assign w_clr_last = (r_clr == WA_W'(PWR_D - 1));

    always_comb begin
        case (r_state)
            F_IDLE:  w_pwr_ra = w_win_x[WA_W-1:0];
            F_RD1:   w_pwr_ra = w_lag_x[WA_W-1:0];
            default: w_pwr_ra = r_wpos;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == F_CLEAR) begin
            if ({1'b0, r_clr} < (WA_W+1)'(LAG)) begin
                r_smp_mem[r_clr[SA_W-1:0]] <= '0;
            end
            if ({1'b0, r_clr} < (WA_W+1)'(WINDOW_LEN)) begin
                r_pre_mem[r_clr[PA_W-1:0]] <= '0;
                r_pim_mem[r_clr[PA_W-1:0]] <= '0;
            end
            r_pwr_mem[r_clr] <= '0;
        end else if (r_state == F_UPD) begin
            r_smp_mem[r_spos] <= {r_im, r_re};
            r_pre_mem[r_ppos] <= r_pr;
            r_pim_mem[r_ppos] <= r_pi;
            r_pwr_mem[r_wpos] <= r_pw[POWER_W-1:0];
        end
        r_smp_rd <= r_smp_mem[r_spos];
        r_pre_rd <= r_pre_mem[r_ppos];
        r_pim_rd <= r_pim_mem[r_ppos];
        r_pwr_rd <= r_pwr_mem[w_pwr_ra];
    end

    // shared multiplier, one product per cycle
    assign w_ore = r_smp_rd[SAMPLE_W-1:0];
    assign w_oim = r_smp_rd[2*SAMPLE_W-1:SAMPLE_W];

    always_comb begin
        case (r_k)
            3'd0:    begin w_ma = w_ore; w_mb = r_re; end
            3'd1:    begin w_ma = w_oim; w_mb = r_im; end
            3'd2:    begin w_ma = w_oim; w_mb = r_re; end
            3'd3:    begin w_ma = w_ore; w_mb = r_im; end
            3'd4:    begin w_ma = r_re;  w_mb = r_re; end
            default: begin w_ma = r_im;  w_mb = r_im; end
        endcase
    end

    assign w_mul   = w_ma * w_mb;
    assign w_mul_x = PROD_W'(w_mul);

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_re <= i_re;
            r_im <= i_im;
        end
        if (r_state == F_RD1) begin
            r_pwin <= r_pwr_rd;
        end
        if (r_state == F_RD2) begin
            r_plag <= r_pwr_rd;
        end
        if (r_state == F_MUL) begin
            case (r_k)
                3'd0:    r_pr <= w_mul_x;
                3'd1:    r_pr <= r_pr + w_mul_x;
                3'd2:    r_pi <= w_mul_x;
                3'd3:    r_pi <= r_pi - w_mul_x;
                3'd4:    r_pw <= w_mul_x;
                default: r_pw <= r_pw + w_mul_x;
            endcase
        end
    end

    // divisor: larger power sum, raised to the floor, and raised to one if still zero
    assign w_floor = DIV_W'(i_floor);
    assign w_max   = (r_pw_rec > r_pw_lag) ? DIV_W'(r_pw_rec) : DIV_W'(r_pw_lag);
    assign w_hit   = (w_max < w_floor);
    always_comb begin
        w_div = w_hit ? w_floor : w_max;
        if (w_div == '0) begin
            w_div = DIV_W'(1);
        end
    end

    assign o_ready     = (r_state == F_IDLE);
    assign o_push      = (r_state == F_PUSH) && !i_full;
    assign o_sum_re    = r_ps_re;
    assign o_sum_im    = r_ps_im;
    assign o_div       = w_div;
    assign o_floor_hit = w_hit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_CLEAR: if (w_clr_last) n_state = F_IDLE;
            F_IDLE:  if (i_valid) n_state = F_RD1;
            F_RD1:   n_state = F_RD2;
            F_RD2:   n_state = F_MUL;
            F_MUL:   if (r_k == 3'd5) n_state = F_UPD;
            F_UPD:   n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_CLEAR;
            r_clr    <= '0;
            r_k      <= '0;
            r_spos   <= '0;
            r_ppos   <= '0;
            r_wpos   <= '0;
            r_ps_re  <= '0;
            r_ps_im  <= '0;
            r_pw_rec <= '0;
            r_pw_lag <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_CLEAR) begin
                r_clr <= r_clr + WA_W'(1);
            end
            if (r_state == F_MUL) begin
                r_k <= r_k + 3'd1;
            end else begin
                r_k <= '0;
            end
            if (r_state == F_UPD) begin
                r_spos <= ({1'b0, r_spos} == (SA_W+1)'(LAG - 1)) ? '0 : r_spos + SA_W'(1);
                r_ppos <= ({1'b0, r_ppos} == (PA_W+1)'(WINDOW_LEN - 1)) ? '0
                                                                        : r_ppos + PA_W'(1);
                r_wpos <= (r_wpos == WA_W'(PWR_D - 1)) ? '0 : r_wpos + WA_W'(1);
                r_ps_re  <= r_ps_re + PS_W'(r_pr) - PS_W'($signed(r_pre_rd));
                r_ps_im  <= r_ps_im + PS_W'(r_pi) - PS_W'($signed(r_pim_rd));
                r_pw_rec <= r_pw_rec + PW_SUM_W'(r_pw[POWER_W-1:0]) - PW_SUM_W'(r_pwin);
                r_pw_lag <= r_pw_lag + PW_SUM_W'(r_plag) - PW_SUM_W'(r_pwr_rd);
            end
        end
    end

endmodule

/* hw/rtl/nlac_back.sv */
module nlac_back #(
    parameter int PS_W  = 39,
    parameter int DIV_W = 38
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_pop,
    input  logic signed [PS_W-1:0] i_sum_re,
    input  logic signed [PS_W-1:0] i_sum_im,
    input  logic [DIV_W-1:0]       i_div,
    input  logic                   i_floor_hit,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [31:0]            o_tdata,
    output logic                   o_tuser
);
    import nlac_pkg::*;

    localparam int CMP_W = (PS_W > DIV_W + 1) ? PS_W : DIV_W + 1;

    t_back_state r_state, n_state;

    logic [3:0]       r_cnt;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem_re, r_rem_im;
    logic [QUO_W-1:0] r_q_re, r_q_im;
    logic             r_lsb_re, r_lsb_im;
    logic             r_neg_re, r_neg_im;
    logic             r_sat_re, r_sat_im;
    logic             r_hit;
    logic             r_out_valid;
    logic [QUO_W-1:0] r_out_re, r_out_im;
    logic             r_out_hit;

    logic [PS_W-1:0]  w_mag_re, w_mag_im;
    logic [CMP_W-1:0] w_div2;
    logic [DIV_W:0]   w_t_re, w_t_im, w_dx;
    logic             w_ge_re, w_ge_im;
    logic             w_load;
    logic [QUO_W-1:0] w_res_re, w_res_im;

    assign w_mag_re = i_sum_re[PS_W-1] ? PS_W'(-i_sum_re) : PS_W'(i_sum_re);
    assign w_mag_im = i_sum_im[PS_W-1] ? PS_W'(-i_sum_im) : PS_W'(i_sum_im);
    assign w_div2   = CMP_W'({i_div, 1'b0});

    // one restoring step per cycle on each part
    assign w_dx    = {1'b0, r_div};
    assign w_t_re  = {r_rem_re, r_lsb_re};
    assign w_t_im  = {r_rem_im, r_lsb_im};
    assign w_ge_re = (w_t_re >= w_dx);
    assign w_ge_im = (w_t_im >= w_dx);

    function automatic logic [QUO_W-1:0] sat_q(input logic sat, input logic neg,
                                              input logic [QUO_W-1:0] q);
        logic [QUO_W-1:0] res;
        if (neg) begin
            res = (sat || q >= SAT_NEG) ? SAT_NEG : QUO_W'(-q);
        end else begin
            res = (sat || q >= SAT_POS) ? SAT_POS : q;
        end
        return res;
    endfunction

    assign w_res_re = sat_q(r_sat_re, r_neg_re, r_q_re);
    assign w_res_im = sat_q(r_sat_im, r_neg_im, r_q_im);

    assign o_pop  = (r_state == B_IDLE) && i_valid;
    assign w_load = (r_state == B_DONE) && (!r_out_valid || i_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (i_valid) n_state = B_RUN;
            B_RUN:   if (r_cnt == 4'd0) n_state = B_DONE;
            B_DONE:  if (w_load) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_div    <= i_div;
            r_hit    <= i_floor_hit;
            r_neg_re <= i_sum_re[PS_W-1];
            r_neg_im <= i_sum_im[PS_W-1];
            r_sat_re <= (CMP_W'(w_mag_re) >= w_div2);
            r_sat_im <= (CMP_W'(w_mag_im) >= w_div2);
            r_rem_re <= DIV_W'(w_mag_re >> 1);
            r_rem_im <= DIV_W'(w_mag_im >> 1);
            r_lsb_re <= w_mag_re[0];
            r_lsb_im <= w_mag_im[0];
        end else if (r_state == B_RUN) begin
            r_rem_re <= w_ge_re ? DIV_W'(w_t_re - w_dx) : w_t_re[DIV_W-1:0];
            r_rem_im <= w_ge_im ? DIV_W'(w_t_im - w_dx) : w_t_im[DIV_W-1:0];
            r_q_re   <= {r_q_re[QUO_W-2:0], w_ge_re};
            r_q_im   <= {r_q_im[QUO_W-2:0], w_ge_im};
            r_lsb_re <= 1'b0;
            r_lsb_im <= 1'b0;
        end
        if (w_load) begin
            r_out_re  <= w_res_re;
            r_out_im  <= w_res_im;
            r_out_hit <= r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cnt <= 4'(QUO_W - 1);
            end else if (r_state == B_RUN) begin
                r_cnt <= r_cnt - 4'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {r_out_im, r_out_re};
    assign o_tuser  = r_out_hit;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RUN && !r_sat_re) |-> (r_rem_re < r_div))
        else $error("real remainder not below divisor");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RUN) |-> (r_div != '0))
        else $error("zero divisor in divider");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_tvalid && r_state == B_IDLE))
        else $error("finished result not presented");
`endif

endmodule

/* hw/rtl/normalized_lag_autocorrelation.sv */
// channel   | direction | payload (lowest bit first)           | handshake
// ----------+-----------+---------------------------------------+---------------------
// s_axis    | in        | tdata: sample_re[15:0] sample_im[31:16] | tvalid / tready
// m_axis    | out       | tdata: corr_re[15:0] corr_im[31:16],  | tvalid / tready
//           |           | tuser: floor_used                     |
// cfg       | in        | data: power_floor[36:0]               | valid / ready (always)
//
// the front takes one sample at a time (read taps, six products on one multiplier,
// sum update, hand-off); the back divides both parts bit by bit, then loads the output,
// so sustained throughput is set by the shift-subtract divider
// after reset the delay memories are zeroed, one address per cycle, over all
// LAG + WINDOW_LEN addresses; s_axis_tready stays low until that pass is done
// a two-entry queue between front and back, and the output register, let either side stall
module normalized_lag_autocorrelation #(
    parameter int WINDOW_LEN = 64,
    parameter int LAG        = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // sample_re, sample_im
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // corr_re, corr_im
    output logic        o_m_axis_tuser,   // floor_used
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [nlac_pkg::FLOOR_W-1:0] i_cfg_data   // power_floor
);
    import nlac_pkg::*;

    // sum widths grow with the window length
    localparam int PS_W     = PROD_W + $clog2(WINDOW_LEN);
    localparam int PW_SUM_W = POWER_W + $clog2(WINDOW_LEN);
    localparam int DIV_W    = (PW_SUM_W > FLOOR_W) ? PW_SUM_W : FLOOR_W;
    localparam int Q_W      = 2 * PS_W + DIV_W + 1;

    logic [FLOOR_W-1:0] r_floor;

    // front to queue
    logic                   w_push, w_full;
    logic signed [PS_W-1:0] w_f_re, w_f_im;
    logic [DIV_W-1:0]       w_f_div;
    logic                   w_f_hit;

    // queue to back
    logic             w_q_valid, w_pop;
    logic [Q_W-1:0]   w_q_data;

    // power floor register: the user makes writes only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_W'(1);
        end else if (i_cfg_valid) begin
            r_floor <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    nlac_front #(
        .WINDOW_LEN (WINDOW_LEN),
        .LAG        (LAG),
        .PS_W       (PS_W),
        .PW_SUM_W   (PW_SUM_W),
        .DIV_W      (DIV_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_floor     (r_floor),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_re        (i_s_axis_tdata[15:0]),
        .i_im        (i_s_axis_tdata[31:16]),
        .o_push      (w_push),
        .i_full      (w_full),
        .o_sum_re    (w_f_re),
        .o_sum_im    (w_f_im),
        .o_div       (w_f_div),
        .o_floor_hit (w_f_hit)
    );

    // sums, divisor and floor flag wait here for the divider
    nlac_fifo #(
        .W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_hit, w_f_div, w_f_im, w_f_re}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    nlac_back #(
        .PS_W  (PS_W),
        .DIV_W (DIV_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_pop       (w_pop),
        .i_sum_re    (w_q_data[PS_W-1:0]),
        .i_sum_im    (w_q_data[2*PS_W-1:PS_W]),
        .i_div       (w_q_data[2*PS_W+DIV_W-1:2*PS_W]),
        .i_floor_hit (w_q_data[Q_W-1]),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tuser     (o_m_axis_tuser)
    );

endmodule

/* tb/nlac_checker.sv */
`timescale 1ns / 100ps

module nlac_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [31:0] i_s_data,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [31:0] i_m_data,
    input  logic        i_m_user,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [nlac_pkg::FLOOR_W-1:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    localparam int WIN = 64;
    localparam int LAGN = 64;
    localparam int PDEP = WIN + LAGN;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic        fl;
    } t_corr;

    t_corr       corr_q[$];
    logic [36:0] floor_r;
    logic [31:0] samp_mem [LAGN];
    longint      prod_re_mem [WIN];
    longint      prod_im_mem [WIN];
    longint      pow_mem [PDEP];
    longint      psum_re, psum_im, pw_recent, pw_lagged;
    int          spos, ppos, wpos;

    assign o_pending = corr_q.size();

    function automatic logic [15:0] scale_sat(longint num, longint dv);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< 15) / dv;
        if (num < 0) return (q >= 32768) ? 16'h8000 : 16'(-q);
        return (q >= 32767) ? 16'h7fff : 16'(q);
    endfunction

    task automatic correlate(input logic [31:0] d);
        longint re, im, ore, oim, pr, pi, pnew, dv;
        t_corr c;
        re  = longint'($signed(d[15:0]));
        im  = longint'($signed(d[31:16]));
        ore = longint'($signed(samp_mem[spos][15:0]));
        oim = longint'($signed(samp_mem[spos][31:16]));
        samp_mem[spos] = d;
        spos = (spos + 1) % LAGN;
        pr = ore * re + oim * im;
        pi = oim * re - ore * im;
        psum_re += pr - prod_re_mem[ppos];
        psum_im += pi - prod_im_mem[ppos];
        prod_re_mem[ppos] = pr;
        prod_im_mem[ppos] = pi;
        ppos = (ppos + 1) % WIN;
        pnew = re * re + im * im;
        pw_recent += pnew - pow_mem[(wpos + PDEP - WIN) % PDEP];
        pw_lagged += pow_mem[(wpos + PDEP - LAGN) % PDEP] - pow_mem[wpos];
        pow_mem[wpos] = pnew;
        wpos = (wpos + 1) % PDEP;
        dv = (pw_recent > pw_lagged) ? pw_recent : pw_lagged;
        c.fl = dv < longint'(floor_r);
        if (c.fl) dv = longint'(floor_r);
        if (dv == 0) dv = 1;
        c.re = scale_sat(psum_re, dv);
        c.im = scale_sat(psum_im, dv);
        corr_q.push_back(c);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_corr w;
        if (!i_rst_n) begin
            o_errors = 0;
            corr_q.delete();
            floor_r = 37'd1;
            for (int k = 0; k < LAGN; k++) samp_mem[k] = '0;
            for (int k = 0; k < WIN; k++) begin
                prod_re_mem[k] = 0;
                prod_im_mem[k] = 0;
            end
            for (int k = 0; k < PDEP; k++) pow_mem[k] = 0;
            psum_re = 0; psum_im = 0; pw_recent = 0; pw_lagged = 0;
            spos = 0; ppos = 0; wpos = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) floor_r = i_cfg_data;
            if (i_s_valid && i_s_ready) correlate(i_s_data);
            if (i_m_valid && i_m_ready) begin
                if (corr_q.size() == 0) begin
                    report("unexpected item", i_m_data, 0);
                end else begin
                    w = corr_q.pop_front();
                    if (i_m_data[15:0] !== w.re) report("corr_re", i_m_data[15:0], w.re);
                    if (i_m_data[31:16] !== w.im) report("corr_im", i_m_data[31:16], w.im);
                    if (i_m_user !== w.fl) report("floor_used", i_m_user, w.fl);
                end
            end
        end
    end
endmodule

/* tb/tb_normalized_lag_autocorrelation.sv */
`timescale 1ns / 100ps

module tb_normalized_lag_autocorrelation;
    import nlac_pkg::*;

    localparam int WATCHDOG = 20000;   // idle cycles before giving up

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic        m_user;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [FLOOR_W-1:0] cfg_data = '0;
    int          errors, pending;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;       // last part of the run: no idling
    bit          hold_off = 1'b0;   // long receiver stall for back pressure

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    normalized_lag_autocorrelation uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    nlac_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data), .i_m_user(m_user),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: ready toggles in random bursts, unless calm or held off
    always @(posedge i_clk) begin
        int n;
        if (hold_off) begin
            m_ready <= 1'b0;
        end else if (calm || $urandom_range(3) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            n = $urandom_range(17, 1);
            repeat (n) @(posedge i_clk);
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one sample offered and held until accepted, with an optional idle burst first
    task automatic send_sample(input logic [15:0] re, input logic [15:0] im);
        int n;
        if (!calm && $urandom_range(5) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(17, 1);
            repeat (n) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {im, re};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    // wait for the block to drain, then leave it idle a while
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [FLOOR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random sample: mostly full range, sometimes extremes or tiny values
    task automatic random_sample();
        logic [15:0] re, im;
        case ($urandom_range(5))
            0: begin re = $urandom_range(1) ? 16'h8000 : 16'h7fff;
                     im = $urandom_range(1) ? 16'h8000 : 16'h7fff; end
            1: begin re = 16'($signed($urandom_range(8)) - 4);
                     im = 16'($signed($urandom_range(8)) - 4); end
            default: begin re = $urandom; im = $urandom; end
        endcase
        send_sample(re, im);
    endtask

    initial begin
        logic [FLOOR_W-1:0] floors [5];
        floors[0] = '1;
        floors[1] = '0;
        floors[2] = 37'd1 << 30;
        floors[3] = 37'd5000;
        floors[4] = 37'd1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // startup with the reset floor: zero samples, extremes, tiny values
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h7fff);
        send_sample(16'h7fff, 16'h7fff);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'hffff, 16'h0001);
        drain();

        // floor zero with four zero samples; the windows still hold earlier power
        write_floor('0);
        repeat (4) send_sample(16'h0000, 16'h0000);
        drain();

        // floor equal to a known power sum: after 130 ones the recent sum is 64
        write_floor(37'd64);
        repeat (130) send_sample(16'h0001, 16'h0000);
        drain();
        write_floor(37'd65);
        send_sample(16'h0001, 16'h0000);
        drain();

        // random phases across several floors
        for (int ph = 0; ph < 5; ph++) begin
            write_floor(floors[ph] ^ (ph == 3 ? 37'($urandom) : 37'd0));
            for (int k = 0; k < 200; k++) begin
                if (ph == 1 && k == 20) begin
                    hold_off = 1'b1;
                    fork
                        begin repeat (300) @(posedge i_clk); hold_off = 1'b0; end
                    join_none
                end
                if (ph == 4 && k == 100) calm = 1'b1;
                random_sample();
            end
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
